@@ sv/obst_pkg.sv @@
// ----------------------------------------------------------------------------
// Optimal BST cost table package
// Shared widths, default parameter values and codes for the optimal binary
// search tree cost and root table block.
// ----------------------------------------------------------------------------
package obst_pkg;

   localparam int MAX_KEYS_DEF    = 64;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int WEIGHT_W = 16;
   localparam int RANGE_W  = 7;
   localparam int COST_W   = 28;
   localparam int ROOT_W   = 7;
   localparam int KIND_W   = 2;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STORED = 2'd0,
      KIND_BUILT  = 2'd1,
      KIND_ANSWER = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUERY,
      ST_START,
      ST_READ,
      ST_EVAL,
      ST_STORE,
      ST_DONE
   } state_type;

endpackage

@@ sv/optimal_bst_cost_table.sv @@
// ----------------------------------------------------------------------------
// Optimal BST cost table
// Loads key weights, builds the optimal binary search tree cost and root
// tables with one shared add-compare unit, and answers range queries.
// ----------------------------------------------------------------------------
// A load word that is not flagged last is acknowledged with a stored word, and a
// query word passes through a query state before its answer. The load word that
// is flagged last starts the table build, which runs over every range of two or
// more keys and every candidate root in it: a read and an evaluate step per
// candidate root plus a store step per range. The single add-compare unit takes
// one candidate from the two read ports of the cost memory at a time. The block
// stalls its input while a word is in work or a stalled result word is held.
module optimal_bst_cost_table
   import obst_pkg::*;
#(
   parameter int MAX_KEYS    = MAX_KEYS_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic                req_is_last,
   input  logic [RANGE_W-1:0]  req_range_first,
   input  logic [RANGE_W-1:0]  req_range_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [COST_W-1:0]   rsp_range_cost,
   output logic [ROOT_W-1:0]   rsp_root_key,
   output logic                rsp_error
);

   localparam int KW     = $clog2(MAX_KEYS + 2);
   localparam int COLS   = MAX_KEYS + 1;
   localparam int DEPTH  = (MAX_KEYS + 2) * COLS;
   localparam int AW     = $clog2(DEPTH);
   localparam int SUM_W  = WEIGHT_BITS + KW;
   localparam int CW     = WEIGHT_BITS + 2 * KW;
   localparam int CMPW   = (CW > COST_W) ? CW : COST_W;
   localparam int QW     = ((KW > RANGE_W) ? KW : RANGE_W) + 1;
   localparam logic [AW-1:0] COLS_A = AW'(COLS);

   logic [CW-1:0]          cost_mem [DEPTH];
   logic [KW-1:0]          root_mem [DEPTH];
   logic [WEIGHT_BITS-1:0] wgt_mem  [MAX_KEYS + 2];

   state_type              state_ff, state_in;
   logic [KW-1:0]          count_ff, count_in;
   logic                   built_ff, built_in;
   logic [KW-1:0]          d_ff, d_in, i_ff, i_in, k_ff, k_in;
   logic [CW-1:0]          best_ff, best_in;
   logic [KW-1:0]          bestk_ff, bestk_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   first_ff, first_in;
   logic                   lemp_ff, lemp_in, remp_ff, remp_in;
   logic                   err_ff, err_in, qemp_ff, qemp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [COST_W-1:0]      rsp_cost_ff, rsp_cost_in;
   logic [ROOT_W-1:0]      rsp_root_ff, rsp_root_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic [CW-1:0]          qa_ff, qb_ff;
   logic [KW-1:0]          rq_ff;
   logic [WEIGHT_BITS-1:0] wq_ff;

   logic                   cw_en, ww_en;
   logic [AW-1:0]          cw_addr, ra_addr, rb_addr;
   logic [CW-1:0]          cw_data;
   logic [KW-1:0]          rw_data, ww_addr, base;
   logic [WEIGHT_BITS-1:0] wval;
   logic [KW-1:0]          j;
   logic [CW-1:0]          cand;
   logic [QW-1:0]          fq, lq, cq;
   logic                   q_bad, q_empty;

   function automatic logic [AW-1:0] tab_addr(input logic [KW-1:0] row,
                                              input logic [KW-1:0] col);
      tab_addr = AW'(row) * COLS_A + AW'(col);
   endfunction

   assign j    = i_ff + d_ff;
   assign wval = WEIGHT_BITS'(req_weight);
   assign cand = (lemp_ff ? '0 : qa_ff) + (remp_ff ? '0 : qb_ff);

   assign fq      = QW'(req_range_first);
   assign lq      = QW'(req_range_last);
   assign cq      = QW'(count_ff);
   assign q_bad   = !built_ff || fq == '0 || fq > cq + 1'b1 || lq > cq || lq + 1'b1 < fq;
   assign q_empty = lq + 1'b1 == fq;

   assign ra_addr = (state_ff == ST_IDLE)
                    ? tab_addr(KW'(req_range_first), KW'(req_range_last))
                    : tab_addr(i_ff, k_ff - 1'b1);
   assign rb_addr = tab_addr(k_ff + 1'b1, j);

   always_ff @(posedge clock) begin
      if (cw_en) begin
         cost_mem[cw_addr] <= cw_data;
         root_mem[cw_addr] <= rw_data;
      end
      if (ww_en) begin
         wgt_mem[ww_addr] <= wval;
      end
      qa_ff <= cost_mem[ra_addr];
      qb_ff <= cost_mem[rb_addr];
      rq_ff <= root_mem[ra_addr];
      wq_ff <= wgt_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff        <= d_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      best_ff     <= best_in;
      bestk_ff    <= bestk_in;
      sum_ff      <= sum_in;
      first_ff    <= first_in;
      lemp_ff     <= lemp_in;
      remp_ff     <= remp_in;
      err_ff      <= err_in;
      qemp_ff     <= qemp_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_root_ff <= rsp_root_in;
      rsp_err_ff  <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      built_in     = built_ff;
      d_in         = d_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      best_in      = best_ff;
      bestk_in     = bestk_ff;
      sum_in       = sum_ff;
      first_in     = first_ff;
      lemp_in      = lemp_ff;
      remp_in      = remp_ff;
      err_in       = err_ff;
      qemp_in      = qemp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_root_in  = rsp_root_ff;
      rsp_err_in   = rsp_err_ff;
      cw_en        = 1'b0;
      cw_addr      = tab_addr(i_ff, j);
      cw_data      = best_ff + CW'(sum_ff);
      rw_data      = bestk_ff;
      ww_en        = 1'b0;
      base         = built_ff ? '0 : count_ff;
      ww_addr      = base + 1'b1;
      req_stall    = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               if (req_cmd == CMD_LOAD) begin
                  built_in = 1'b0;
                  err_in   = 1'b0;
                  count_in = base;
                  if (base < KW'(MAX_KEYS)) begin
                     count_in = base + 1'b1;
                     ww_en    = 1'b1;
                     cw_en    = 1'b1;
                     cw_addr  = tab_addr(base + 1'b1, base + 1'b1);
                     cw_data  = CW'(wval);
                     rw_data  = base + 1'b1;
                  end else begin
                     err_in = 1'b1;
                  end
                  if (req_is_last) begin
                     state_in = ST_START;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_STORED;
                     rsp_cost_in  = '0;
                     rsp_root_in  = '0;
                     rsp_err_in   = !(base < KW'(MAX_KEYS));
                  end
               end else begin
                  err_in   = q_bad;
                  qemp_in  = q_empty;
                  state_in = ST_QUERY;
               end
            end
         end
         ST_QUERY: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_ANSWER;
            rsp_err_in   = err_ff;
            if (err_ff || qemp_ff) begin
               rsp_cost_in = '0;
               rsp_root_in = '0;
            end else begin
               rsp_cost_in = (CMPW'(qa_ff) > CMPW'(COST_MAX)) ? COST_MAX : COST_W'(qa_ff);
               rsp_root_in = ROOT_W'(rq_ff);
            end
            state_in = ST_IDLE;
         end
         ST_START: begin
            d_in     = KW'(1);
            i_in     = KW'(1);
            k_in     = KW'(1);
            sum_in   = '0;
            first_in = 1'b1;
            state_in = (count_ff < KW'(2)) ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            lemp_in  = (k_ff == i_ff);
            remp_in  = (k_ff == j);
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (first_ff || cand < best_ff) begin
               best_in  = cand;
               bestk_in = k_ff;
            end
            first_in = 1'b0;
            sum_in   = sum_ff + SUM_W'(wq_ff);
            if (k_ff == j) begin
               state_in = ST_STORE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_STORE: begin
            cw_en    = 1'b1;
            sum_in   = '0;
            first_in = 1'b1;
            state_in = ST_READ;
            if (j == count_ff) begin
               d_in = d_ff + 1'b1;
               i_in = KW'(1);
               k_in = KW'(1);
               if (d_ff + 1'b1 == count_ff) begin
                  state_in = ST_DONE;
               end
            end else begin
               i_in = i_ff + 1'b1;
               k_in = i_ff + 1'b1;
            end
         end
         ST_DONE: begin
            built_in     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_BUILT;
            rsp_cost_in  = '0;
            rsp_root_in  = '0;
            rsp_err_in   = err_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_range_cost = rsp_cost_ff;
   assign rsp_root_key   = rsp_root_ff;
   assign rsp_error      = rsp_err_ff;

endmodule

@@ sv/obst_checker.sv @@
// ----------------------------------------------------------------------------
// Optimal BST cost table checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module obst_checker
   import obst_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_cmd,
   input logic                req_is_last,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [KIND_W-1:0]   rsp_kind,
   input logic [COST_W-1:0]   rsp_range_cost,
   input logic [ROOT_W-1:0]   rsp_root_key,
   input logic                rsp_error
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_range_cost) && $stable(rsp_root_key) && $stable(rsp_error))
      else $error("stalled result word changed");

   // Load acknowledgments carry no cost and no root.
   a_ack_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ANSWER |-> rsp_range_cost == '0 && rsp_root_key == '0)
      else $error("load acknowledgment carries cost or root");

   // A rejected query returns zero cost and root.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ANSWER && rsp_error |->
      rsp_range_cost == '0 && rsp_root_key == '0)
      else $error("rejected query carries cost or root");

   // A load that does not end the set is acknowledged in the next cycle.
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == CMD_LOAD && !req_is_last |=>
      rsp_valid && rsp_kind == KIND_STORED)
      else $error("load word not acknowledged");

endmodule

bind optimal_bst_cost_table obst_checker u_obst_checker (.*);

@@ test/optimal_bst_cost_table_tb.sv @@
// ----------------------------------------------------------------------------
// Optimal BST cost table testbench
// Loads sets of key weights, lets the block build its cost and root tables,
// and queries ranges, checking every response word against a local predictor
// of the optimal binary search tree recurrence. Both channels idle at random.
// ----------------------------------------------------------------------------
module optimal_bst_cost_table_tb;
   import obst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NKEYS = 64;

   typedef struct {
      kind_type          kind;
      logic [COST_W-1:0] cost;
      logic [ROOT_W-1:0] root;
      logic              error;
   } answer_type;

   class scoreboard_type;
      longint unsigned weights[NKEYS+1];
      longint unsigned costs[NKEYS+2][NKEYS+1];
      int unsigned     roots[NKEYS+2][NKEYS+1];
      int unsigned     count;
      bit              built;
      answer_type      pending[$];
      int              errors;

      function void build_tables();
         longint unsigned sums[NKEYS+1];
         longint unsigned best, v;
         int unsigned     bk, j;
         sums[0] = 0;
         for (int i = 1; i <= count; i++) sums[i] = sums[i-1] + weights[i];
         for (int i = 1; i <= count + 1; i++) begin
            costs[i][i-1] = 0;
            roots[i][i-1] = 0;
         end
         for (int i = 1; i <= count; i++) begin
            costs[i][i] = weights[i];
            roots[i][i] = i;
         end
         for (int d = 1; d < count; d++) begin
            for (int i = 1; i + d <= count; i++) begin
               j = i + d;
               best = costs[i][i-1] + costs[i+1][j];
               bk = i;
               for (int k = i + 1; k <= j; k++) begin
                  v = costs[i][k-1] + costs[k+1][j];
                  if (v < best) begin
                     best = v;
                     bk = k;
                  end
               end
               costs[i][j] = best + sums[j] - sums[i-1];
               roots[i][j] = bk;
            end
         end
         built = 1;
      endfunction

      function void note_word(cmd_type cmd, logic [WEIGHT_W-1:0] w, logic last,
                              logic [RANGE_W-1:0] f, logic [RANGE_W-1:0] l);
         answer_type a;
         a.cost = '0;
         a.root = '0;
         a.error = 0;
         if (cmd == CMD_LOAD) begin
            if (built) begin
               built = 0;
               count = 0;
            end
            if (count < NKEYS) begin
               count++;
               weights[count] = w;
            end else begin
               a.error = 1;
            end
            if (last) begin
               build_tables();
               a.kind = KIND_BUILT;
            end else begin
               a.kind = KIND_STORED;
            end
         end else begin
            a.kind = KIND_ANSWER;
            if (!built || f < 1 || f > count + 1 || l > count || l + 1 < f) begin
               a.error = 1;
            end else if (l + 1 != f) begin
               a.cost = (costs[f][l] > COST_MAX) ? COST_MAX : COST_W'(costs[f][l]);
               a.root = ROOT_W'(roots[f][l]);
            end
         end
         pending.push_back(a);
      endfunction

      function void check_word(logic [KIND_W-1:0] kind, logic [COST_W-1:0] cost,
                               logic [ROOT_W-1:0] root, logic error);
         answer_type a;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word kind %0d cost %0d root %0d error %0d",
                     $realtime, kind, cost, root, error);
            errors++;
            return;
         end
         a = pending.pop_front();
         if (kind !== a.kind) begin
            $display("%0t: kind expected %0d actual %0d", $realtime, a.kind, kind);
            errors++;
         end
         if (cost !== a.cost) begin
            $display("%0t: cost expected %0d actual %0d", $realtime, a.cost, cost);
            errors++;
         end
         if (root !== a.root) begin
            $display("%0t: root expected %0d actual %0d", $realtime, a.root, root);
            errors++;
         end
         if (error !== a.error) begin
            $display("%0t: error expected %0d actual %0d", $realtime, a.error, error);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_stall;
   logic                req_cmd = 0;
   logic [WEIGHT_W-1:0] req_weight = '0;
   logic                req_is_last = 0;
   logic [RANGE_W-1:0]  req_range_first = '0;
   logic [RANGE_W-1:0]  req_range_last = '0;
   logic                rsp_valid;
   logic                rsp_stall = 0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [COST_W-1:0]   rsp_range_cost;
   logic [ROOT_W-1:0]   rsp_root_key;
   logic                rsp_error;

   int             send_idle_pct;
   int             recv_idle_pct;
   scoreboard_type board;

   optimal_bst_cost_table u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall)
            board.check_word(rsp_kind, rsp_range_cost, rsp_root_key, rsp_error);
      end
   end

   task automatic send_word(cmd_type cmd, logic [WEIGHT_W-1:0] w, logic last,
                            logic [RANGE_W-1:0] f, logic [RANGE_W-1:0] l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_weight <= w;
      req_is_last <= last;
      req_range_first <= f;
      req_range_last <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_word(cmd, w, last, f, l);
   endtask

   task automatic load_set(int n, int wmode);
      logic [WEIGHT_W-1:0] w;
      for (int i = 1; i <= n; i++) begin
         case (wmode)
            0: w = WEIGHT_W'($urandom);
            1: w = '1;
            2: w = WEIGHT_W'($urandom_range(15));
            default: w = '0;
         endcase
         send_word(CMD_LOAD, w, i == n, RANGE_W'($urandom), RANGE_W'($urandom));
      end
   endtask

   task automatic query_random();
      int n;
      int f;
      int l;
      n = board.count;
      case ($urandom_range(9))
         0: begin
            f = $urandom_range(127);
            l = $urandom_range(127);
         end
         1: begin
            f = $urandom_range(n + 1, 1);
            l = f - 1;
         end
         default: begin
            f = $urandom_range(n, 1);
            l = $urandom_range(n, f);
         end
      endcase
      send_word(CMD_QUERY, WEIGHT_W'($urandom), 1'($urandom), RANGE_W'(f), RANGE_W'(l));
   endtask

   task automatic phase(int sp, int rp);
      send_idle_pct = sp;
      recv_idle_pct = rp;
      load_set($urandom_range(8, 1), $urandom_range(3));
      repeat (6) query_random();
   endtask

   initial begin
      board = new();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd1, 7'd1);
      load_set(3, 3);
      send_word(CMD_QUERY, 16'hffff, 1'b1, 7'd1, 7'd3);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd0, 7'd0);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd4, 7'd3);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd5, 7'd4);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd2, 7'd0);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd127, 7'd127);
      for (int i = 1; i <= NKEYS; i++)
         send_word(CMD_LOAD, '1, 1'b0, 7'd0, 7'd0);
      send_word(CMD_LOAD, 16'h1234, 1'b1, 7'd0, 7'd0);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd1, 7'd64);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd65, 7'd64);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd64, 7'd64);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd1, 7'd65);
      send_word(CMD_QUERY, 16'h0000, 1'b0, 7'd10, 7'd40);
      phase(17, 58);
      phase(58, 17);
      phase(0, 0);
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0)
         $display("PASS optimal_bst_cost_table");
      else
         $display("FAIL optimal_bst_cost_table");
      $finish;
   end

   initial begin
      #50ms;
      $display("FAIL optimal_bst_cost_table");
      $finish;
   end

endmodule
